FILE: rtl/pkrt_pkg.sv
// ----------------------------------------------------------------------------
// pkrt_pkg
// Shared constants and types for the pressed-key rollover tracker.
// ----------------------------------------------------------------------------
package pkrt_pkg;

    localparam int MaxKeys  = 6;
    localparam int CntW     = $clog2(MaxKeys + 1);
    localparam int IdxW     = (MaxKeys > 1) ? $clog2(MaxKeys) : 1;
    localparam int NumSlots = 6;

    localparam logic [15:0] EvtKey  = 16'h0001;
    localparam logic [15:0] EvtSync = 16'h0000;

    typedef logic [CntW-1:0] t_cnt;
    typedef logic [IdxW-1:0] t_idx;
    typedef logic [NumSlots-1:0][7:0] t_slots;

    typedef struct packed {
        logic [15:0] event_type;
        logic [7:0]  scan_code;
        logic        pressed;
    } t_in_item;

    typedef struct packed {
        logic [2:0] held_num;
        logic [7:0] slot0;
        logic [7:0] slot1;
        logic [7:0] slot2;
        logic [7:0] slot3;
        logic [7:0] slot4;
        logic [7:0] slot5;
        logic       sync_seen;
        logic       read_ready;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        LOP_NONE,
        LOP_APPEND,
        LOP_SHIFT,
        LOP_DEC
    } t_list_op;

    typedef struct packed {
        t_list_op   op;
        t_idx       idx;
        logic [7:0] code;
    } t_list_cmd;

    typedef struct packed {
        logic in_range;
        logic hit;
    } t_cmp_res;

endpackage

FILE: rtl/pkrt_if.sv
// ----------------------------------------------------------------------------
// pkrt_in_if / pkrt_out_if
// Valid/ready channels for key events and list reports.
// ----------------------------------------------------------------------------
interface pkrt_in_if;
    logic               valid;
    logic               ready;
    pkrt_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pkrt_out_if;
    logic                valid;
    logic                ready;
    pkrt_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/pkrt_cmp.sv
// ----------------------------------------------------------------------------
// pkrt_cmp
// Shared compare unit: bounds check of an entry index and code match.
// ----------------------------------------------------------------------------
module pkrt_cmp (
    input  pkrt_pkg::t_cnt     i_idx,
    input  pkrt_pkg::t_cnt     i_count,
    input  logic [7:0]         i_entry,
    input  logic [7:0]         i_code,
    output pkrt_pkg::t_cmp_res o_res
);

    always_comb begin
        o_res.in_range = (i_idx < i_count);
        o_res.hit      = o_res.in_range && (i_entry == i_code);
    end

endmodule

FILE: rtl/pkrt_list.sv
// ----------------------------------------------------------------------------
// pkrt_list
// Held-key storage: entry registers, count, one indexed read port.
// ----------------------------------------------------------------------------
module pkrt_list (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pkrt_pkg::t_list_cmd i_cmd,
    input  pkrt_pkg::t_cnt      i_rd_idx,
    output logic [7:0]          o_rd_data,
    output pkrt_pkg::t_cnt      o_count,
    output pkrt_pkg::t_slots    o_slots
);

    logic [7:0]     r_keys [pkrt_pkg::MaxKeys];
    pkrt_pkg::t_cnt r_count;
    pkrt_pkg::t_cnt n_count;

    assign o_rd_data = r_keys[i_rd_idx[pkrt_pkg::IdxW-1:0]];
    assign o_count   = r_count;

    always_comb begin
        n_count = r_count;
        unique case (i_cmd.op)
            pkrt_pkg::LOP_APPEND: n_count = r_count + 1'b1;
            pkrt_pkg::LOP_DEC:    n_count = r_count - 1'b1;
            pkrt_pkg::LOP_NONE,
            pkrt_pkg::LOP_SHIFT:  n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == pkrt_pkg::LOP_APPEND) begin
            r_keys[i_cmd.idx] <= i_cmd.code;
        end else if (i_cmd.op == pkrt_pkg::LOP_SHIFT) begin
            r_keys[i_cmd.idx] <= o_rd_data;
        end
    end

    for (genvar g = 0; g < pkrt_pkg::NumSlots; g++) begin : g_slot
        if (g < pkrt_pkg::MaxKeys) begin : g_used
            assign o_slots[g] = (pkrt_pkg::t_cnt'(g) < r_count) ? r_keys[g] : 8'h00;
        end else begin : g_unused
            assign o_slots[g] = 8'h00;
        end
    end

endmodule

FILE: rtl/pressed_key_rollover_tracker.sv
// ----------------------------------------------------------------------------
// pressed_key_rollover_tracker
// Ordered list of held key codes, updated one event at a time.
//
//   channel   dir   payload                                   transfer
//   i_evt     in    event_type, scan_code, pressed            valid & ready
//   o_rpt     out   held_num, slot0..slot5, sync_seen,        valid & ready
//                   read_ready
//   i_cfg_*   in    enabled                                   i_cfg_we
//
// A sync, stray or disabled event goes straight to the report; for a key event
// one shared comparator walks the list one entry a cycle, and a release shifts
// later entries down one per cycle.
// Reset (i_rst_n low, synchronous) empties the list and disables the block.
// One event is in work at a time; a report waiting on o_rpt holds the
// sequencer in its final state until it is taken.
// ----------------------------------------------------------------------------
module pressed_key_rollover_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    pkrt_in_if.sink     i_evt,
    pkrt_out_if.source  o_rpt
);

    pkrt_pkg::t_state    r_state, n_state;
    pkrt_pkg::t_cnt      r_idx, n_idx;
    logic [7:0]          r_code, n_code;
    logic                r_press, n_press;
    logic                r_sync, n_sync;
    logic                r_enabled;
    logic                r_out_valid;
    pkrt_pkg::t_out_item r_out;

    pkrt_pkg::t_list_cmd list_cmd;
    pkrt_pkg::t_cnt      list_count;
    logic [7:0]          list_rd;
    pkrt_pkg::t_slots    list_slots;
    pkrt_pkg::t_cnt      cmp_idx;
    pkrt_pkg::t_cmp_res  cmp_res;
    pkrt_pkg::t_out_item out_item;
    logic                load_out;

    assign cmp_idx = (r_state == pkrt_pkg::ST_SHIFT) ? pkrt_pkg::t_cnt'(r_idx + 1'b1) : r_idx;

    pkrt_cmp u_cmp (
        .i_idx   (cmp_idx),
        .i_count (list_count),
        .i_entry (list_rd),
        .i_code  (r_code),
        .o_res   (cmp_res)
    );

    pkrt_list u_list (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (list_cmd),
        .i_rd_idx  (cmp_idx),
        .o_rd_data (list_rd),
        .o_count   (list_count),
        .o_slots   (list_slots)
    );

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_code       = r_code;
        n_press      = r_press;
        n_sync       = r_sync;
        list_cmd     = '{op: pkrt_pkg::LOP_NONE, idx: r_idx[pkrt_pkg::IdxW-1:0], code: r_code};
        i_evt.ready  = 1'b0;
        load_out     = 1'b0;
        unique case (r_state)
            pkrt_pkg::ST_IDLE: begin
                i_evt.ready = 1'b1;
                if (i_evt.valid) begin
                    n_idx   = '0;
                    n_code  = i_evt.data.scan_code;
                    n_press = i_evt.data.pressed;
                    if (r_enabled && (i_evt.data.event_type == pkrt_pkg::EvtKey)) begin
                        n_sync  = 1'b0;
                        n_state = pkrt_pkg::ST_SCAN;
                    end else begin
                        n_sync  = r_enabled && (i_evt.data.event_type == pkrt_pkg::EvtSync);
                        n_state = pkrt_pkg::ST_DONE;
                    end
                end
            end
            pkrt_pkg::ST_SCAN: begin
                if (!cmp_res.in_range) begin
                    if (r_press && (r_idx < pkrt_pkg::t_cnt'(pkrt_pkg::MaxKeys))) begin
                        list_cmd.op = pkrt_pkg::LOP_APPEND;
                    end
                    n_state = pkrt_pkg::ST_DONE;
                end else if (cmp_res.hit) begin
                    n_state = r_press ? pkrt_pkg::ST_DONE : pkrt_pkg::ST_SHIFT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            pkrt_pkg::ST_SHIFT: begin
                if (cmp_res.in_range) begin
                    list_cmd.op = pkrt_pkg::LOP_SHIFT;
                    n_idx       = r_idx + 1'b1;
                end else begin
                    list_cmd.op = pkrt_pkg::LOP_DEC;
                    n_state     = pkrt_pkg::ST_DONE;
                end
            end
            pkrt_pkg::ST_DONE: begin
                if (!r_out_valid || o_rpt.ready) begin
                    load_out = 1'b1;
                    n_state  = pkrt_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        out_item.held_num   = 3'(list_count);
        out_item.slot0      = list_slots[0];
        out_item.slot1      = list_slots[1];
        out_item.slot2      = list_slots[2];
        out_item.slot3      = list_slots[3];
        out_item.slot4      = list_slots[4];
        out_item.slot5      = list_slots[5];
        out_item.sync_seen  = r_sync;
        out_item.read_ready = (list_count != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pkrt_pkg::ST_IDLE;
            r_enabled   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_enabled <= i_cfg_wdata;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rpt.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_code  <= n_code;
        r_press <= n_press;
        r_sync  <= n_sync;
        if (load_out) begin
            r_out <= out_item;
        end
    end

    assign o_rpt.valid = r_out_valid;
    assign o_rpt.data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        list_count <= pkrt_pkg::t_cnt'(pkrt_pkg::MaxKeys))
        else $error("held count above capacity");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (list_cmd.op == pkrt_pkg::LOP_APPEND) |=>
            (list_count == pkrt_pkg::t_cnt'($past(list_count) + 1'b1)))
        else $error("append did not grow the list");

    a_shift_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pkrt_pkg::ST_SHIFT) |-> (r_idx < list_count))
        else $error("shift pointer outside the list");

    a_sync_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pkrt_pkg::ST_DONE) && r_sync |-> (list_cmd.op == pkrt_pkg::LOP_NONE))
        else $error("list changed on a sync event");

endmodule
